// ===== design/lsbe_pkg.sv =====
// Package for the LED strip serial bit encoder.
// Holds the transfer payload types, the symbol packer result type and fixed constants.
// No dependencies.
package lsbe_pkg;

    typedef struct packed {
        logic       operation;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_in;

    typedef struct packed {
        logic [31:0] out_word;
        logic [8:0]  word_index;
        logic        frame_end;
        logic        overflow;
        logic        last_of_run;
    } t_out;

    typedef struct packed {
        logic        done;
        logic [31:0] word;
        logic [31:0] acc_next;
        logic [4:0]  pos_next;
    } t_pack_res;

    localparam logic        OP_PIXEL       = 1'b0;
    localparam logic        OP_FILL        = 1'b1;
    localparam logic [11:0] PREAMBLE_CODE  = 12'h55A;
    localparam logic [31:0] ALL_ONES       = 32'hFFFF_FFFF;
    localparam int          TAIL_MARGIN    = 10;
    localparam int          FILL_SYMBOLS   = 25;
    localparam int          FILL_BITS      = 150;
    localparam int          PIXEL_SYMBOLS  = 25;
    localparam int          FRAME_SYMBOLS  = 37;
    localparam int          PIXEL_BASE_BITS = 150;
    localparam int          PREAMBLE_BITS  = 96;
    localparam logic [9:0]  SYM_ONE        = 10'b0001111111;
    localparam logic [9:0]  SYM_ZERO       = 10'b0011110000;
    localparam logic [5:0]  SYM_ONE_LEN    = 6'd10;
    localparam logic [5:0]  SYM_ZERO_LEN   = 6'd6;
    localparam logic [2:0]  ADDR_BRIGHTNESS = 3'd0;
    localparam logic [7:0]  BRIGHTNESS_RESET = 8'd1;

endpackage

// ===== design/lsbe_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Depends on nothing but the clock and reset.
module lsbe_div (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [7:0] i_dividend,
    input  logic [7:0] i_divisor,
    output logic       o_done,
    output logic [7:0] o_quotient
);

    logic       r_busy;
    logic       r_done;
    logic [2:0] r_cnt;
    logic [7:0] r_rem;
    logic [7:0] r_quo;
    logic [7:0] r_dvs;
    logic [8:0] trial;
    logic [8:0] diff;
    logic [7:0] n_rem;
    logic [7:0] n_quo;

    always_comb begin
        trial = {r_rem, r_quo[7]};
        diff  = trial - {1'b0, r_dvs};
        if (!diff[8]) begin
            n_rem = diff[7:0];
            n_quo = {r_quo[6:0], 1'b1};
        end else begin
            n_rem = trial[7:0];
            n_quo = {r_quo[6:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== design/lsbe_pack.sv =====
// Symbol packer: places one 6- or 10-bit symbol into the word being filled.
// Depends on lsbe_pkg for the symbol patterns and the result type.
module lsbe_pack
    import lsbe_pkg::*;
(
    input  logic [31:0] i_acc,
    input  logic [4:0]  i_pos,
    input  logic        i_one,
    output t_pack_res   o_res
);

    logic [9:0]  sym;
    logic [5:0]  len;
    logic [41:0] ext;
    logic [5:0]  pos_sum;

    always_comb begin
        sym     = i_one ? SYM_ONE : SYM_ZERO;
        len     = i_one ? SYM_ONE_LEN : SYM_ZERO_LEN;
        ext     = {i_acc, 10'b0} | ({sym, 32'b0} >> i_pos);
        pos_sum = {1'b0, i_pos} + len;
        o_res.done     = pos_sum[5];
        o_res.word     = ext[41:10];
        o_res.acc_next = pos_sum[5] ? {ext[9:0], 22'b0} : ext[41:10];
        o_res.pos_next = pos_sum[4:0];
    end

endmodule

// ===== design/led_strip_serial_bit_encoder_top.sv =====
// Top level of the LED strip serial bit encoder: sequencer, state and output register.
// Depends on lsbe_pkg, lsbe_div and lsbe_pack.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------
//  input    | i_valid / o_stall  | i_data (t_in)
//  output   | o_valid / i_stall  | o_data (t_out)
//  config   | psel penable pwrite| paddr pwdata prdata pready
//
// A pixel takes three divisions and one range check, then one symbol per cycle (25, or 37
// when it opens a frame) while no completed word waits on a stalled output.
// A fill step sends 25 zero symbols, and a frame close then pads out the frame with ones.
// Reset is synchronous and clears the frame state; the brightness divisor resets to one.
// Each completed word is held in the output register until its transfer completes.
module led_strip_serial_bit_encoder_top
    import lsbe_pkg::*;
#(
    parameter int FIRST_BUFFER_WORDS  = 256,
    parameter int SECOND_BUFFER_WORDS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in         i_data,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out        o_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int FRAME_WORDS = FIRST_BUFFER_WORDS + SECOND_BUFFER_WORDS;
    localparam int CW          = $clog2(FRAME_WORDS) + 1;
    localparam logic [CW-1:0] FRAME_LAST = CW'(FRAME_WORDS - 1);
    localparam logic [CW-1:0] LIMIT      = CW'(FRAME_WORDS - TAIL_MARGIN);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DIV   = 7'b0000010,
        S_CHECK = 7'b0000100,
        S_SEND  = 7'b0001000,
        S_PAD   = 7'b0010000,
        S_ONES  = 7'b0100000,
        S_OVF   = 7'b1000000
    } t_state;

    t_state        r_state,     n_state;
    logic [7:0]    r_div;
    t_in           r_in,        n_in;
    logic [1:0]    r_idx,       n_idx;
    logic [23:0]   r_q,         n_q;
    logic [36:0]   r_bits,      n_bits;
    logic [5:0]    r_cnt,       n_cnt;
    logic [CW-1:0] r_end,       n_end;
    logic          r_close,     n_close;
    logic          r_open,      n_open;
    logic [4:0]    r_bp,        n_bp;
    logic [CW-1:0] r_wc,        n_wc;
    logic [31:0]   r_acc,       n_acc;
    logic          r_out_valid, n_out_valid;
    t_out          r_out,       n_out;

    logic          div_start;
    logic [7:0]    div_dividend;
    logic [7:0]    div_eff;
    logic          div_done;
    logic [7:0]    div_quo;
    t_pack_res     pk;
    logic          out_free;
    logic          cfg_write;
    logic [CW+4:0] fill_total;
    logic [CW+4:0] pix_total;
    logic [CW-1:0] fill_end;
    logic [CW-1:0] pix_end;
    logic [4:0]    pix_ones;
    logic [8:0]    pix_len;
    logic          wc_last;

    assign div_eff = (r_div == 8'd0) ? 8'd1 : r_div;

    lsbe_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_eff),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    lsbe_pack u_pack (
        .i_acc (r_acc),
        .i_pos (r_bp),
        .i_one (r_bits[36]),
        .o_res (pk)
    );

    assign cfg_write = psel && penable && pwrite && (paddr[2] == ADDR_BRIGHTNESS[2]);
    assign prdata    = (paddr == ADDR_BRIGHTNESS) ? {24'b0, r_div} : 32'b0;
    assign pready    = 1'b1;

    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;
    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        fill_total = {r_wc, r_bp} + (CW+5)'(FILL_BITS);
        fill_end   = fill_total[CW+4:5];
        pix_ones   = 5'($countones(r_q));
        pix_len    = 9'(PIXEL_BASE_BITS) + {2'b0, pix_ones, 2'b0}
                   + (r_open ? 9'd0 : 9'(PREAMBLE_BITS));
        pix_total  = {r_wc, r_bp} + (CW+5)'(pix_len);
        pix_end    = pix_total[CW+4:5];
        wc_last    = (r_wc == FRAME_LAST);
    end

    always_comb begin
        n_state     = r_state;
        n_in        = r_in;
        n_idx       = r_idx;
        n_q         = r_q;
        n_bits      = r_bits;
        n_cnt       = r_cnt;
        n_end       = r_end;
        n_close     = r_close;
        n_open      = r_open;
        n_bp        = r_bp;
        n_wc        = r_wc;
        n_acc       = r_acc;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_stall;
        div_start   = 1'b0;
        div_dividend = (r_idx == 2'd0) ? r_in.green : r_in.blue;

        unique case (r_state)
            S_IDLE: begin
                div_dividend = i_data.red;
                if (i_valid) begin
                    n_in = i_data;
                    if (i_data.operation == OP_PIXEL) begin
                        div_start = 1'b1;
                        n_idx     = 2'd0;
                        n_state   = S_DIV;
                    end else if (r_open) begin
                        n_bits  = '0;
                        n_cnt   = 6'(FILL_SYMBOLS);
                        n_end   = fill_end;
                        n_close = (fill_end >= LIMIT);
                        n_state = S_SEND;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_q = {r_q[15:0], div_quo};
                    if (r_idx == 2'd2) begin
                        n_state = S_CHECK;
                    end else begin
                        div_start = 1'b1;
                        n_idx     = r_idx + 2'd1;
                    end
                end
            end
            S_CHECK: begin
                if (pix_end >= LIMIT) begin
                    n_state = S_OVF;
                end else begin
                    n_end   = pix_end;
                    n_close = 1'b0;
                    n_open  = 1'b1;
                    n_state = S_SEND;
                    if (r_open) begin
                        n_bits = {r_q, 1'b0, 12'b0};
                        n_cnt  = 6'(PIXEL_SYMBOLS);
                    end else begin
                        n_bits = {PREAMBLE_CODE, r_q, 1'b0};
                        n_cnt  = 6'(FRAME_SYMBOLS);
                    end
                end
            end
            S_SEND: begin
                if (!pk.done || out_free) begin
                    n_acc  = pk.acc_next;
                    n_bp   = pk.pos_next;
                    n_bits = {r_bits[35:0], 1'b0};
                    n_cnt  = r_cnt - 6'd1;
                    if (pk.done) begin
                        n_out_valid       = 1'b1;
                        n_out.out_word    = pk.word;
                        n_out.word_index  = 9'(r_wc);
                        n_out.frame_end   = 1'b0;
                        n_out.overflow    = 1'b0;
                        n_out.last_of_run = (r_wc + CW'(1) == r_end) && !r_close;
                        n_wc              = r_wc + CW'(1);
                    end
                    if (r_cnt == 6'd1) begin
                        n_state = r_close ? S_PAD : S_IDLE;
                    end
                end
            end
            S_PAD, S_ONES: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.out_word    = (r_state == S_PAD) ? (r_acc | (ALL_ONES >> r_bp))
                                                           : ALL_ONES;
                    n_out.word_index  = 9'(r_wc);
                    n_out.frame_end   = wc_last;
                    n_out.overflow    = 1'b0;
                    n_out.last_of_run = wc_last;
                    n_acc             = '0;
                    n_bp              = '0;
                    if (wc_last) begin
                        n_wc    = '0;
                        n_open  = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_wc    = r_wc + CW'(1);
                        n_state = S_ONES;
                    end
                end
            end
            S_OVF: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.out_word    = '0;
                    n_out.word_index  = 9'(r_wc);
                    n_out.frame_end   = 1'b0;
                    n_out.overflow    = 1'b1;
                    n_out.last_of_run = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div       <= BRIGHTNESS_RESET;
            r_open      <= 1'b0;
            r_bp        <= '0;
            r_wc        <= '0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_close     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_open      <= n_open;
            r_bp        <= n_bp;
            r_wc        <= n_wc;
            r_acc       <= n_acc;
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
            r_cnt       <= n_cnt;
            r_close     <= n_close;
            if (cfg_write) begin
                r_div <= pwdata[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_in   <= n_in;
        r_q    <= n_q;
        r_bits <= n_bits;
        r_end  <= n_end;
        r_out  <= n_out;
    end

endmodule

// ===== design/lsbe_chk.sv =====
// Port-level checker for the LED strip serial bit encoder, bound to the top level.
// Depends on lsbe_pkg for the payload types.
module lsbe_chk
    import lsbe_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input t_in         i_data,
    input logic        o_valid,
    input logic        i_stall,
    input t_out        o_data,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("output transfer changed while stalled");

    a_ovf_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.overflow |->
            o_data.last_of_run && !o_data.frame_end && (o_data.out_word == 32'd0))
        else $error("overflow result malformed");

    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.frame_end |-> o_data.last_of_run && !o_data.overflow)
        else $error("frame end is not the last result of its input");

    a_pixel_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_data.operation == OP_PIXEL) |=> o_stall)
        else $error("pixel accepted but block not busy");

    a_cfg_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && pready && (paddr == ADDR_BRIGHTNESS) |=>
            (paddr != ADDR_BRIGHTNESS) || (prdata[7:0] == $past(pwdata[7:0])))
        else $error("brightness register read-back mismatch");

endmodule

bind led_strip_serial_bit_encoder_top lsbe_chk u_lsbe_chk (.*);

// ===== tb/lsbe_checker.sv =====
// Checker for the LED strip serial bit encoder: watches the input, output and register ports,
// predicts every output word from the accepted pixels and fill steps, and compares field by field.
// Depends on lsbe_pkg.
module lsbe_checker
    import lsbe_pkg::*;
#(
    parameter int FIRST_BUFFER_WORDS  = 256,
    parameter int SECOND_BUFFER_WORDS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_in         i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_out        i_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_WORDS = FIRST_BUFFER_WORDS + SECOND_BUFFER_WORDS;
    localparam int CLOSE_WORD  = FRAME_WORDS - TAIL_MARGIN;

    logic [7:0]  divisor;
    int          bit_pos;
    int          word_cnt;
    logic [31:0] acc;
    bit          frame_open;
    t_out        expected_words[$];
    int          err_count = 0;

    assign o_errors = err_count;

    task automatic report(input string what);
        err_count++;
        if (err_count <= 40) begin
            $display("[%0t] checker: %s", $time, what);
        end
    endtask

    function automatic void clear_frame();
        bit_pos    = 0;
        word_cnt   = 0;
        acc        = '0;
        frame_open = 1'b0;
    endfunction

    function automatic void emit_word(input logic [31:0] word, input int idx,
                                      input bit last_word, input bit dropped);
        t_out r;
        r.out_word    = word;
        r.word_index  = 9'(idx);
        r.frame_end   = last_word;
        r.overflow    = dropped;
        r.last_of_run = 1'b0;
        expected_words.push_back(r);
    endfunction

    function automatic void put_bit(input bit b);
        if (b) begin
            acc[31 - bit_pos] = 1'b1;
        end
        bit_pos++;
        if (bit_pos >= 32) begin
            emit_word(acc, word_cnt, 1'b0, 1'b0);
            word_cnt++;
            acc     = '0;
            bit_pos = 0;
        end
    endfunction

    function automatic void put_symbol(input bit one);
        int i;
        for (i = 0; i < (one ? 3 : 2); i++) put_bit(1'b0);
        for (i = 0; i < (one ? 7 : 4); i++) put_bit(1'b1);
    endfunction

    function automatic int symbol_bits(input bit one);
        return one ? int'(SYM_ONE_LEN) : int'(SYM_ZERO_LEN);
    endfunction

    function automatic void encode_pixel(input t_in item);
        int         dd;
        int         len;
        int         i;
        int         c;
        logic [7:0] ch [3];
        dd    = (divisor == 8'd0) ? 1 : int'(divisor);
        ch[0] = 8'(int'(item.red) / dd);
        ch[1] = 8'(int'(item.green) / dd);
        ch[2] = 8'(int'(item.blue) / dd);
        len   = int'(SYM_ZERO_LEN);
        if (!frame_open) begin
            for (i = 0; i < 12; i++) len += symbol_bits(PREAMBLE_CODE[11 - i]);
        end
        for (c = 0; c < 3; c++) begin
            for (i = 0; i < 8; i++) len += symbol_bits(ch[c][7 - i]);
        end
        if ((word_cnt * 32 + bit_pos + len) / 32 >= CLOSE_WORD) begin
            emit_word('0, word_cnt, 1'b0, 1'b1);
        end else begin
            if (!frame_open) begin
                for (i = 0; i < 12; i++) put_symbol(PREAMBLE_CODE[11 - i]);
                frame_open = 1'b1;
            end
            for (c = 0; c < 3; c++) begin
                for (i = 0; i < 8; i++) put_symbol(ch[c][7 - i]);
            end
            put_symbol(1'b0);
        end
    endfunction

    function automatic void encode_fill();
        int s;
        int w;
        if (!frame_open) begin
            return;
        end
        for (s = 0; s < FILL_SYMBOLS; s++) put_symbol(1'b0);
        if (word_cnt >= CLOSE_WORD) begin
            while (bit_pos < 32) begin
                acc[31 - bit_pos] = 1'b1;
                bit_pos++;
            end
            emit_word(acc, word_cnt, word_cnt + 1 >= FRAME_WORDS, 1'b0);
            for (w = word_cnt + 1; w < FRAME_WORDS; w++) begin
                emit_word(ALL_ONES, w, w + 1 == FRAME_WORDS, 1'b0);
            end
            clear_frame();
        end
    endfunction

    function automatic void predict_words(input t_in item);
        int prior_count;
        prior_count = expected_words.size();
        if (item.operation == OP_PIXEL) begin
            encode_pixel(item);
        end else begin
            encode_fill();
        end
        if (expected_words.size() > prior_count) begin
            expected_words[expected_words.size() - 1].last_of_run = 1'b1;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            clear_frame();
            divisor = BRIGHTNESS_RESET;
            expected_words.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    report($sformatf("unexpected word %h at index %0d",
                                     i_out_data.out_word, i_out_data.word_index));
                end else begin
                    want = expected_words.pop_front();
                    if (i_out_data.out_word !== want.out_word)
                        report($sformatf("word %0d: out_word %h, expected %h", want.word_index,
                                         i_out_data.out_word, want.out_word));
                    if (i_out_data.word_index !== want.word_index)
                        report($sformatf("word_index %0d, expected %0d",
                                         i_out_data.word_index, want.word_index));
                    if (i_out_data.frame_end !== want.frame_end)
                        report($sformatf("word %0d: frame_end %b, expected %b", want.word_index,
                                         i_out_data.frame_end, want.frame_end));
                    if (i_out_data.overflow !== want.overflow)
                        report($sformatf("word %0d: overflow %b, expected %b", want.word_index,
                                         i_out_data.overflow, want.overflow));
                    if (i_out_data.last_of_run !== want.last_of_run)
                        report($sformatf("word %0d: last_of_run %b, expected %b",
                                         want.word_index, i_out_data.last_of_run,
                                         want.last_of_run));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_words(i_in_data);
            end
            if (psel && penable && pready && paddr == ADDR_BRIGHTNESS) begin
                if (pwrite) begin
                    divisor = pwdata[7:0];
                end else if (prdata !== {24'b0, divisor}) begin
                    report($sformatf("brightness read %h, expected %h", prdata, divisor));
                end
            end
        end
        o_pending <= expected_words.size();
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the LED strip serial bit encoder testbench: clock, reset, pixel and fill stimulus,
// output stalls and register writes, with the final verdict.
// Depends on lsbe_pkg, lsbe_checker and led_strip_serial_bit_encoder_top.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import lsbe_pkg::*;

    localparam int FIRST_WORDS  = 256;
    localparam int SECOND_WORDS = 256;
    localparam int FRAME_WORDS  = FIRST_WORDS + SECOND_WORDS;
    localparam int CLOSE_WORD   = FRAME_WORDS - TAIL_MARGIN;
    localparam int ONE_EXTRA    = int'(SYM_ONE_LEN) - int'(SYM_ZERO_LEN);

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    t_in         i_data;
    logic        o_valid;
    logic        i_stall;
    t_out        o_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;

    int          items_sent = 0;
    int          frame_bits = 0;
    int          send_quiet = 0;
    bit          long_hold_done = 1'b0;
    logic [7:0]  div_now = BRIGHTNESS_RESET;

    led_strip_serial_bit_encoder_top #(
        .FIRST_BUFFER_WORDS (FIRST_WORDS),
        .SECOND_BUFFER_WORDS(SECOND_WORDS)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_data (o_data),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    lsbe_checker #(
        .FIRST_BUFFER_WORDS (FIRST_WORDS),
        .SECOND_BUFFER_WORDS(SECOND_WORDS)
    ) u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_in_stall (o_stall),
        .i_in_data  (i_data),
        .i_out_valid(o_valid),
        .i_out_stall(i_stall),
        .i_out_data (o_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_errors   (fail_count),
        .o_pending  (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] rand_channel();
        case ($urandom_range(0, 3))
            0: return 8'hFF;
            1: return 8'($urandom | 32'hE0);
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int pixel_bits(input logic [7:0] r, g, b, input logic [7:0] d);
        int dd;
        dd = (d == 8'd0) ? 1 : int'(d);
        return PIXEL_BASE_BITS + ONE_EXTRA * ($countones(int'(r) / dd)
               + $countones(int'(g) / dd) + $countones(int'(b) / dd));
    endfunction

    task automatic send(input t_in item);
        int gap;
        if (send_quiet > 0) begin
            send_quiet--;
            gap = 0;
        end else begin
            gap = pick_gap();
            if ($urandom_range(0, 19) == 0) send_quiet = $urandom_range(10, 30);
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= item;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic push_pixel(input logic [7:0] r, g, b);
        int  len;
        t_in item;
        len = pixel_bits(r, g, b, div_now) + ((frame_bits == 0) ? PREAMBLE_BITS : 0);
        item.operation = OP_PIXEL;
        item.red       = r;
        item.green     = g;
        item.blue      = b;
        send(item);
        if ((frame_bits + len) / 32 < CLOSE_WORD) frame_bits += len;
    endtask

    task automatic push_fill();
        t_in item;
        item.operation = OP_FILL;
        item.red       = 8'($urandom);
        item.green     = 8'($urandom);
        item.blue      = 8'($urandom);
        send(item);
        if (frame_bits != 0) begin
            frame_bits += FILL_BITS;
            if (frame_bits / 32 >= CLOSE_WORD) begin
                frame_bits = 0;
            end
        end
    endtask

    // For divisor 0 or 1, picks a pixel length so the closing fill ends on a word boundary.
    task automatic try_aligned_close();
        int          k;
        int          len;
        int          pick;
        int          rot;
        logic [23:0] ones;
        pick = -1;
        if (div_now <= 8'd1) begin
            for (k = 0; k <= 24; k++) begin
                len = frame_bits + PIXEL_BASE_BITS + ONE_EXTRA * k;
                if (pick < 0 && len / 32 < CLOSE_WORD && (len + FILL_BITS) % 32 == 0
                    && (len + FILL_BITS) / 32 >= CLOSE_WORD) pick = k;
            end
        end
        if (pick >= 0) begin
            ones = (24'h1 << pick) - 24'h1;
            rot  = $urandom_range(0, 23);
            ones = (ones << rot) | (ones >> (24 - rot));
            push_pixel(ones[23:16], ones[15:8], ones[7:0]);
        end
        push_fill();
    endtask

    task automatic random_step();
        int r;
        r = $urandom_range(0, 99);
        if (frame_bits == 0) begin
            if (r < 10) push_fill();
            else push_pixel(rand_channel(), rand_channel(), rand_channel());
        end else if (frame_bits >= (CLOSE_WORD - 13) * 32) begin
            if (r < 35) push_pixel(8'hFF, rand_channel(), 8'hFF);
            else if (r < 65) try_aligned_close();
            else push_fill();
        end else if (r < 12) begin
            push_fill();
        end else begin
            push_pixel(rand_channel(), rand_channel(), rand_channel());
        end
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
    endtask

    task automatic apb_access(input bit wr, input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_divisor(input logic [7:0] d);
        wait_idle();
        apb_access(1'b1, ADDR_BRIGHTNESS, {24'b0, d});
        apb_access(1'b0, ADDR_BRIGHTNESS, '0);
        div_now = d;
    endtask

    initial begin : receiver
        int span;
        int r;
        bit hold;
        i_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            r = $urandom_range(0, 99);
            if (!long_hold_done && items_sent >= 25) begin
                hold           = 1'b1;
                span           = 300;
                long_hold_done = 1'b1;
            end else if (r < 8) begin
                hold = 1'b0;
                span = $urandom_range(30, 80);
            end else if (r < 45) begin
                hold = 1'b1;
                span = (r < 40) ? $urandom_range(1, 3) : $urandom_range(10, 40);
            end else begin
                hold = 1'b0;
                span = $urandom_range(1, 6);
            end
            i_stall <= hold;
            repeat (span - 1) @(negedge i_clk);
        end
    end

    initial begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int n;
        i_clk   = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        apb_access(1'b0, ADDR_BRIGHTNESS, '0);

        push_fill();
        push_pixel(8'h00, 8'h00, 8'h00);
        push_pixel(8'hFF, 8'hFF, 8'hFF);
        push_pixel(8'h80, 8'h01, 8'hAA);
        push_fill();
        push_pixel(8'h55, 8'h7F, 8'hFE);
        set_divisor(8'd0);
        push_pixel(8'hFF, 8'h80, 8'h03);
        push_pixel(8'h07, 8'h00, 8'hFF);
        set_divisor(8'd255);
        push_pixel(8'hFF, 8'hFE, 8'h00);
        push_fill();
        set_divisor(8'd3);
        push_pixel(8'd200, 8'd100, 8'd50);
        push_fill();

        while (items_sent < 100) begin
            repeat (30) random_step();
            case ($urandom_range(0, 4))
                0: set_divisor(8'd1);
                1: set_divisor(8'd0);
                2: set_divisor(8'd255);
                3: set_divisor(8'($urandom_range(2, 6)));
                default: set_divisor(8'($urandom_range(7, 254)));
            endcase
        end

        i_valid <= 1'b0;
        for (n = 0; n < 50000 && pending != 0; n++) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        if (pending != 0) $display("%0d expected words never arrived", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
